>>> rtl/tmvb_pkg.sv
// tmvb_pkg: shared widths, mode codes and defaults for the vertex ball walker
// no dependencies
package tmvb_pkg;
	localparam int MAX_ELEMENTS_D = 1024;
	localparam int MAX_VERTICES_D = 4096;
	localparam int LIST_MAX_D     = 64;
	localparam int ELEM_W  = 10;
	localparam int SLOT_W  = 2;
	localparam int VAL_W   = 12;
	localparam int STAMP_W = 16;
	typedef enum logic [1:0] {
		MODE_CORNER = 2'd0,
		MODE_FACE   = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;
endpackage

>>> rtl/tmvb_ram.sv
// tmvb_ram: generic single write port, single read port ram, registered read
// no dependencies
module tmvb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/tetra_mesh_vertex_ball_unit.sv
// tetra_mesh_vertex_ball_unit: vertex ball walker over a tetrahedral mesh
// depends on tmvb_pkg and tmvb_ram
// writes: one beat each, no result
// query: fetch the vertex, then per queue entry read it and, per face looked at, read
//   the neighbour; a boundary or already visited one is passed over, else its corners
//   are compared; each step is a ram read then a compare, the rams set the pace
// reset: control state clears at once, then a sweep over all MAX_ELEMENTS entries clears
//   the visit marks before the first beat is taken; a stamp wrap repeats it
module tetra_mesh_vertex_ball_unit
	import tmvb_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_D,
	parameter int MAX_VERTICES = MAX_VERTICES_D,
	parameter int LIST_MAX     = LIST_MAX_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	output logic              ready_in,
	input  logic [1:0]        mode,
	input  logic [ELEM_W-1:0] element,
	input  logic [SLOT_W-1:0] slot,
	input  logic [VAL_W-1:0]  value,
	output logic              valid_out,
	input  logic              ready_out,
	output logic [ELEM_W-1:0] ball_element,
	output logic [SLOT_W-1:0] local_corner,
	output logic              last,
	output logic              overflow
);
	localparam int EA_W = $clog2(MAX_ELEMENTS);
	localparam int TA_W = EA_W + 2;
	localparam int QA_W = $clog2(LIST_MAX);
	localparam int CNT_W = QA_W + 1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_START, ST_HEAD, ST_FACE, ST_NBR, ST_MARK,
		ST_CORN, ST_CMP, ST_OUT_RD, ST_OUT
	} state_t;

	state_t state_q;

	// table ram ports
	logic              cv_we, fn_we, vm_we, bq_we;
	logic [TA_W-1:0]   cv_wa, cv_ra, fn_ra;
	logic [VAL_W-1:0]  cv_rd, fn_rd, bq_rd;
	logic [EA_W-1:0]   vm_wa, vm_ra;
	logic [STAMP_W-1:0] vm_wd, vm_rd;
	logic [QA_W-1:0]   bq_wa, bq_ra;
	logic [VAL_W-1:0]  bq_wd;

	// walk registers
	logic [EA_W-1:0]    clr_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [VAL_W-1:0]   vert_q;
	logic [CNT_W-1:0]   count_q, head_q, out_q;
	logic [EA_W-1:0]    cur_q, nb_q;
	logic [1:0]         face_q, corn_q;
	logic [1:0]         steps_q;
	logic               cut_q;
	logic [ELEM_W-1:0]  qel_q;
	logic [SLOT_W-1:0]  qsl_q;
	logic [VAL_W-1:0]   nb_code;
	logic [VAL_W-2-1:0] nb_el;
	logic               nb_ok;

	logic acc_in;
	logic el_ok;
	assign ready_in = (state_q == ST_IDLE);
	assign acc_in   = valid_in && ready_in;
	assign el_ok    = (element != '0) && ({22'd0, element} < 32'(MAX_ELEMENTS));

	assign nb_code = fn_rd;
	assign nb_el   = nb_code[VAL_W-1:2];
	assign nb_ok   = (nb_el != '0) && ({22'd0, nb_el} < 32'(MAX_ELEMENTS));

	// table writes share the port with nothing else since walks only read
	assign cv_we = acc_in && el_ok && (mode == MODE_CORNER) &&
		({20'd0, value} < 32'(MAX_VERTICES));
	assign fn_we = acc_in && el_ok && (mode == MODE_FACE);
	assign cv_wa = {element[EA_W-1:0], slot};

	always_comb begin
		cv_ra = {cur_q, qsl_q};
		fn_ra = {cur_q, face_q};
		case (state_q)
			// a wrap sweep ends straight into the query, so hold the start corner
			ST_CLEAR: cv_ra = {qel_q[EA_W-1:0], qsl_q};
			ST_IDLE:  cv_ra = {element[EA_W-1:0], slot};
			ST_CORN:  cv_ra = {nb_q, corn_q};
			ST_CMP:   cv_ra = {nb_q, corn_q + 2'd1};
			default:  cv_ra = {nb_q, corn_q};
		endcase
	end

	// visit marks: cleared by sweep, written with stamp
	always_comb begin
		vm_we = 1'b0;
		vm_wa = nb_q;
		vm_wd = stamp_q;
		vm_ra = nb_el[EA_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				vm_we = 1'b1;
				vm_wa = clr_q;
				vm_wd = '0;
			end
			ST_START: begin
				vm_we = 1'b1;
				vm_wa = qel_q[EA_W-1:0];
			end
			// mark of the held neighbour is back from the read
			ST_CORN: vm_we = (vm_rd != stamp_q);
			default: ;
		endcase
	end

	assign bq_ra = (state_q == ST_FACE || state_q == ST_HEAD) ? head_q[QA_W-1:0]
		: out_q[QA_W-1:0];

	tmvb_ram #(.WIDTH(VAL_W), .DEPTH(4 * MAX_ELEMENTS)) u_corner (
		.clk, .we(cv_we), .waddr(cv_wa), .wdata(value), .raddr(cv_ra), .rdata(cv_rd));
	tmvb_ram #(.WIDTH(VAL_W), .DEPTH(4 * MAX_ELEMENTS)) u_face (
		.clk, .we(fn_we), .waddr(cv_wa), .wdata(value), .raddr(fn_ra), .rdata(fn_rd));
	tmvb_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_ELEMENTS)) u_marks (
		.clk, .we(vm_we), .waddr(vm_wa), .wdata(vm_wd), .raddr(vm_ra), .rdata(vm_rd));
	tmvb_ram #(.WIDTH(VAL_W), .DEPTH(LIST_MAX)) u_queue (
		.clk, .we(bq_we), .waddr(bq_wa), .wdata(bq_wd), .raddr(bq_ra), .rdata(bq_rd));

	logic             hit;
	assign hit = (cv_rd == vert_q);

	always_comb begin
		bq_we = 1'b0;
		bq_wa = count_q[QA_W-1:0];
		bq_wd = VAL_W'({nb_q, corn_q});
		case (state_q)
			ST_START: begin
				bq_we = 1'b1;
				bq_wa = '0;
				bq_wd = {qel_q, qsl_q};
			end
			ST_CMP: bq_we = hit && (count_q < CNT_W'(LIST_MAX));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			stamp_q   <= '0;
			valid_out <= 1'b0;
			count_q   <= '0;
			head_q    <= '0;
			out_q     <= '0;
			cut_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (32'(clr_q) == MAX_ELEMENTS - 1) begin
						clr_q <= '0;
						if (stamp_q == '1) begin
							stamp_q <= STAMP_W'(1);
							state_q <= ST_START;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (acc_in && el_ok && mode == MODE_QUERY) begin
						qel_q <= element;
						qsl_q <= slot;
						// corner word read now, taken as vertex in ST_START; a stamp wrap runs the sweep first
						if (stamp_q == '1) begin
							state_q <= ST_CLEAR;
						end else begin
							stamp_q <= stamp_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					// vertex id arrives from the corner read
					vert_q  <= cv_rd;
					count_q <= CNT_W'(1);
					head_q  <= '0;
					cut_q   <= 1'b0;
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					// queue entry at the head is read this cycle
					if (head_q >= count_q) begin
						out_q   <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						state_q <= ST_FACE;
						steps_q <= '0;
					end
				end
				ST_FACE: begin
					cur_q   <= bq_rd[TA_W-1:2];
					face_q  <= bq_rd[1:0] + 2'd1;
					state_q <= ST_NBR;
				end
				ST_NBR: begin
					// face read issued with cur_q, face_q this cycle; the word is back in ST_MARK
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					// mark read in flight; hold neighbour
					nb_q   <= nb_el[EA_W-1:0];
					corn_q <= '0;
					if (nb_ok) begin
						state_q <= ST_CORN;
					end else begin
						if (steps_q == 2'd2) begin
							head_q  <= head_q + 1'b1;
							state_q <= ST_HEAD;
						end else begin
							state_q <= ST_NBR;
						end
						steps_q <= steps_q + 1'b1;
						face_q  <= face_q + 2'd1;
					end
				end
				ST_CORN: begin
					if (vm_rd == stamp_q) begin
						if (steps_q == 2'd2) begin
							head_q  <= head_q + 1'b1;
							state_q <= ST_HEAD;
						end else begin
							state_q <= ST_NBR;
						end
						steps_q <= steps_q + 1'b1;
						face_q  <= face_q + 2'd1;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (hit || corn_q == 2'd3) begin
						if (hit && count_q >= CNT_W'(LIST_MAX)) begin
							cut_q   <= 1'b1;
							out_q   <= '0;
							state_q <= ST_OUT_RD;
						end else begin
							if (hit) count_q <= count_q + 1'b1;
							if (steps_q == 2'd2) begin
								head_q  <= head_q + 1'b1;
								state_q <= ST_HEAD;
							end else begin
								state_q <= ST_NBR;
							end
							steps_q <= steps_q + 1'b1;
							face_q  <= face_q + 2'd1;
						end
					end else begin
						corn_q <= corn_q + 2'd1;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!valid_out) begin
						valid_out    <= 1'b1;
						ball_element <= ELEM_W'(bq_rd[VAL_W-1:2]);
						local_corner <= bq_rd[1:0];
						last         <= (out_q + 1'b1 == count_q);
						overflow     <= cut_q;
					end else if (ready_out) begin
						valid_out <= 1'b0;
						out_q     <= out_q + 1'b1;
						state_q   <= (out_q + 1'b1 == count_q) ? ST_IDLE : ST_OUT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a result beat only stands while the walker is in its output phase
	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> state_q == ST_OUT)
		else $error("result beat outside output phase");
	// the ball never holds more than its limit
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_MAX))
		else $error("ball count past limit");
	// no input taken while a result waits
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> !ready_in)
		else $error("input ready during output");
endmodule
